// File: sv/dqs_pkg.sv
package dqs_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 3;

    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W:0]   CAP_WIDE = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE      = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_SEARCH
    } state_t;

    function automatic logic [IDX_W-1:0] ring_add(
        input logic [IDX_W-1:0] a,
        input logic [IDX_W-1:0] b
    );
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CAP_WIDE)
        begin
            s = s - CAP_WIDE;
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// File: sv/double_ended_queue_with_search.sv
// Pushes and undefined opcodes: the result strobe follows in the cycle after the request.
// Pops: the entry is read into the store's read register, and ST_POP then registers it
// with the result strobe; a pop on an empty queue answers in the cycle after the request.
// Search: one stored entry compared per cycle from the front, until a match or the last one.
// A new request is taken in the cycle in which the result is shown; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the queue; the entry store itself is not cleared.
module double_ended_queue_with_search
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dqs_pkg::OP_W-1:0]     opcode,
    input  logic signed [dqs_pkg::DATA_W-1:0] operand_value,
    output logic                         strobe,
    output logic [dqs_pkg::STAT_W-1:0]   status,
    output logic signed [dqs_pkg::DATA_W-1:0] popped_value,
    output logic [dqs_pkg::CNT_W-1:0]    occupancy
);

    logic [dqs_pkg::DATA_W-1:0] mem [dqs_pkg::CAPACITY];
    logic [dqs_pkg::DATA_W-1:0] rd_data_reg;

    dqs_pkg::state_t              state_reg, state_next;
    logic [dqs_pkg::IDX_W-1:0]    front_reg, front_next;
    logic [dqs_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [dqs_pkg::IDX_W-1:0]    offset_reg, offset_next;
    logic [dqs_pkg::DATA_W-1:0]   key_reg, key_next;

    logic                         strobe_reg, strobe_next;
    dqs_pkg::status_t             status_reg, status_next;
    logic [dqs_pkg::DATA_W-1:0]   popped_reg, popped_next;
    logic [dqs_pkg::CNT_W-1:0]    occ_reg, occ_next;

    logic                         wr_en;
    logic [dqs_pkg::IDX_W-1:0]    wr_addr;
    logic [dqs_pkg::IDX_W-1:0]    rd_addr;
    logic [dqs_pkg::CNT_W-1:0]    offset_inc;
    logic                         accept;

    assign accept     = start && (state_reg == dqs_pkg::ST_IDLE);
    assign busy       = (state_reg != dqs_pkg::ST_IDLE);
    assign offset_inc = {1'b0, offset_reg} + dqs_pkg::CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= operand_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dqs_pkg::ST_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
        occ_reg    <= occ_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        key_next    = key_reg;
        strobe_next = 1'b0;
        status_next = dqs_pkg::STAT_DONE;
        popped_next = '0;
        occ_next    = count_reg;
        wr_en       = 1'b0;
        wr_addr     = dqs_pkg::ring_add(front_reg, count_reg[dqs_pkg::IDX_W-1:0]);
        rd_addr     = front_reg;

        unique case (state_reg)
            dqs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        dqs_pkg::OP_PUSH_BACK:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg >= dqs_pkg::CAP_CNT)
                            begin
                                status_next = dqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + dqs_pkg::CNT_W'(1);
                                occ_next   = count_next;
                            end
                        end
                        dqs_pkg::OP_PUSH_FRONT:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg >= dqs_pkg::CAP_CNT)
                            begin
                                status_next = dqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = dqs_pkg::ring_add(front_reg, dqs_pkg::IDX_LAST);
                                front_next = wr_addr;
                                count_next = count_reg + dqs_pkg::CNT_W'(1);
                                occ_next   = count_next;
                            end
                        end
                        dqs_pkg::OP_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = dqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = front_reg;
                                front_next = dqs_pkg::ring_add(front_reg,
                                                               dqs_pkg::IDX_W'(1));
                                count_next = count_reg - dqs_pkg::CNT_W'(1);
                                state_next = dqs_pkg::ST_POP;
                            end
                        end
                        dqs_pkg::OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = dqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - dqs_pkg::CNT_W'(1);
                                rd_addr    = dqs_pkg::ring_add(front_reg,
                                                 count_next[dqs_pkg::IDX_W-1:0]);
                                state_next = dqs_pkg::ST_POP;
                            end
                        end
                        dqs_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = dqs_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                rd_addr     = front_reg;
                                offset_next = '0;
                                key_next    = operand_value;
                                state_next  = dqs_pkg::ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end
            dqs_pkg::ST_POP:
            begin
                strobe_next = 1'b1;
                popped_next = rd_data_reg;
                state_next  = dqs_pkg::ST_IDLE;
            end
            dqs_pkg::ST_SEARCH:
            begin
                if (rd_data_reg == key_reg)
                begin
                    strobe_next = 1'b1;
                    status_next = dqs_pkg::STAT_FOUND;
                    state_next  = dqs_pkg::ST_IDLE;
                end
                else if (offset_inc == count_reg)
                begin
                    strobe_next = 1'b1;
                    status_next = dqs_pkg::STAT_NOT_FOUND;
                    state_next  = dqs_pkg::ST_IDLE;
                end
                else
                begin
                    offset_next = offset_inc[dqs_pkg::IDX_W-1:0];
                    rd_addr     = dqs_pkg::ring_add(front_reg, offset_next);
                end
            end
            default:
            begin
                state_next = dqs_pkg::ST_IDLE;
            end
        endcase
    end

    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign occupancy    = occ_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dqs_pkg::CAP_CNT)
        else $error("Entry count exceeds capacity.");

    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (occ_reg == count_reg))
        else $error("Reported occupancy differs from the held entry count.");

    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && (popped_reg != '0)) |-> (status_reg == dqs_pkg::STAT_DONE))
        else $error("Non-zero popped value with a status other than done.");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (count_reg == '0)
            && ((opcode == dqs_pkg::OP_POP_FRONT) || (opcode == dqs_pkg::OP_POP_BACK)))
        |=> (strobe_reg && (status_reg == dqs_pkg::STAT_EMPTY)))
        else $error("Pop request on an empty queue did not report empty.");
`endif

endmodule
